FILE: rtl/core/rbva_pkg.sv
// Shared types, constants and helper functions for the radial bin visibility accumulator.
// No dependencies; every other file in rtl/core but rbva_checker imports this package.
package rbva_pkg;

	localparam logic [62:0] POWER_MAX = '1;

	typedef enum logic [0:0] {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_RING_COUNT = 1'b0,
		REG_RING_WIDTH = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_BND,
		ST_CMP,
		ST_SQRT,
		ST_UPD,
		ST_RD,
		ST_RDW,
		ST_DIVS,
		ST_DIV_RE,
		ST_DIV_IM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [63:0] real_s;
		logic signed [63:0] imag_s;
		logic [62:0]        power_s;
		logic signed [63:0] noise_s;
		logic [31:0]        count;
	} entry_t;

	// Handshake between the sequencer and a multi-cycle arithmetic unit.
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		abs32 = x[31] ? 32'(-x) : 32'(x);
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		abs64 = x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [31:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {{33{b[31]}}, b};
		if (s[64] != s[63]) begin
			sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	// A squared bound past 32 integer bits stands above any possible distance.
	function automatic logic [63:0] bound_sq(input logic [63:0] p);
		bound_sq = (p[63:32] != 32'd0) ? '1 : {p[31:0], 32'd0};
	endfunction

	function automatic logic [31:0] mean_clamp(input logic neg, input logic [63:0] q);
		logic [63:0] c;
		if (neg) begin
			c = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
			mean_clamp = 32'(64'd0 - c);
		end else begin
			mean_clamp = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
	endfunction

endpackage

FILE: rtl/core/rbva_sqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on rbva_pkg for the start/done handshake types.
module rbva_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  rbva_pkg::unit_req_t req,
	input  logic [63:0]       radicand,
	output rbva_pkg::unit_rsp_t rsp,
	output logic [31:0]       root
);
	import rbva_pkg::*;

	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [34:0] rem_n;
	logic [34:0] trial;

	assign rem_n = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

FILE: rtl/core/rbva_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on rbva_pkg for the start/done handshake types.
module rbva_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rbva_pkg::unit_req_t req,
	input  logic [63:0]       dividend,
	input  logic [31:0]       divisor,
	output rbva_pkg::unit_rsp_t rsp,
	output logic [63:0]       quotient
);
	import rbva_pkg::*;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] rem_n;

	assign rem_n = {rem_q, quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_q <= 32'(rem_n - {1'b0, dvs_q});
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_n[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/radial_bin_visibility_accumulator.sv
// Top level of the radial bin visibility accumulator: sequencer, shared multiplier, ring store.
// Depends on rbva_pkg, rbva_sqrt and rbva_div.
//
// An add item squares u, v, real and imaginary parts on one shared 32x32 multiplier, then
// walks the rings outward, up to ring_count rings (held to 1..MAX_RINGS), squaring each
// bound on the same multiplier. The magnitude comes from the bit-serial square root, the
// ring entry is read and written back, and the two means take one pass each through the
// shared bit-serial divider; a read of an empty ring skips the divider. One item is in
// work at a time; in_ready is high only between items, and a finished result waits in the
// output register so the next item can start meanwhile. The ring store clears at reset
// through one valid bit per ring, so no clearing pass is needed.
module radial_bin_visibility_accumulator #(
	parameter int MAX_RINGS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [0:0]         op,
	input  logic signed [31:0] u_pos,
	input  logic signed [31:0] v_pos,
	input  logic signed [31:0] vis_real,
	input  logic signed [31:0] vis_imag,
	input  logic signed [31:0] vis_noise,
	input  logic [3:0]         ring_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         ring_index,
	output logic [0:0]         out_of_range,
	output logic [31:0]        item_count,
	output logic signed [63:0] real_sum,
	output logic signed [63:0] imag_sum,
	output logic [62:0]        power_sum,
	output logic signed [63:0] noise_sum,
	output logic signed [31:0] real_mean,
	output logic signed [31:0] imag_mean
);
	import rbva_pkg::*;

	localparam int AW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
	localparam int CW = $clog2(MAX_RINGS + 1);
	localparam int RW = CW + 16;
	localparam logic [8:0] MAX9 = 9'(MAX_RINGS);

	state_t state_q, state_d;

	logic [4:0]  ring_count_q;
	logic [15:0] ring_width_q;

	logic signed [31:0] u_q, v_q, re_q, im_q, nz_q;
	logic [3:0]        sel_q;
	logic [2:0]        step_q;
	logic [63:0]       prod_q, d2_q, p2_q;
	logic [RW-1:0]     r_q;
	logic [CW-1:0]     i_q, n_q;
	logic [AW-1:0]     k_q;
	logic              oor_q;
	logic [3:0]        ridx_q;
	entry_t            cur_q;
	logic [31:0]       mre_q, mim_q;

	entry_t            ring_mem [MAX_RINGS];
	logic [MAX_RINGS-1:0] ring_vld_q;
	entry_t            rd_q;
	logic              rd_vld_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	entry_t            ent, upd;

	logic              out_valid_q;
	logic [3:0]        ring_index_q;
	logic              oor_out_q;
	entry_t            res_q;
	logic [31:0]       rmean_q, imean_q;

	logic              out_load;
	unit_req_t         sq_req, dv_req;
	unit_rsp_t         sq_rsp, dv_rsp;
	logic [31:0]       mag;
	logic [63:0]       quo;
	logic [63:0]       dv_dividend;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] bnd;
	logic [8:0]  n9, rc9;
	logic        sel_ok;
	logic [AW+3:0] sel_x, k_x;
	logic [63:0] pw_sum;

	// Shared multiplier with operand select.
	always_comb begin
		mul_a = 32'(r_q);
		mul_b = 32'(r_q);
		if (state_q == ST_SQ) begin
			case (step_q)
				3'd0: begin mul_a = abs32(u_q);  mul_b = abs32(u_q);  end
				3'd1: begin mul_a = abs32(v_q);  mul_b = abs32(v_q);  end
				3'd2: begin mul_a = abs32(re_q); mul_b = abs32(re_q); end
				default: begin mul_a = abs32(im_q); mul_b = abs32(im_q); end
			endcase
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	assign bnd    = bound_sq(prod_q);
	assign rc9    = {4'd0, ring_count_q};
	assign n9     = (rc9 == 9'd0) ? 9'd1 : ((rc9 > MAX9) ? MAX9 : rc9);
	assign sel_ok = ({5'd0, sel_q} < MAX9);
	assign sel_x  = {AW'(0), sel_q};
	assign k_x    = {4'd0, k_q};
	assign rd_addr = (state_q == ST_RD) ? sel_x[AW-1:0] : k_q;

	assign ent = rd_vld_q ? rd_q : '0;
	assign pw_sum = {1'b0, ent.power_s} + 64'(mag);
	always_comb begin
		upd.real_s  = sat_add(ent.real_s, re_q);
		upd.imag_s  = sat_add(ent.imag_s, im_q);
		upd.noise_s = sat_add(ent.noise_s, nz_q);
		upd.power_s = (pw_sum > {1'b0, POWER_MAX}) ? POWER_MAX : pw_sum[62:0];
		upd.count   = (ent.count == '1) ? ent.count : ent.count + 32'd1;
	end
	assign wr_en = (state_q == ST_UPD);

	assign dv_dividend = (state_q == ST_DIVS) ? abs64(cur_q.real_s) : abs64(cur_q.imag_s);

	// Sequencer next state and unit controls.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		sq_req.start = 1'b0;
		dv_req.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (op == OP_READ) ? ST_RD : ST_SQ;
				end
			end
			ST_SQ: begin
				if (step_q == 3'd4) state_d = ST_BND;
			end
			ST_BND: state_d = ST_CMP;
			ST_CMP: begin
				if (i_q == n_q) begin
					if (d2_q > bnd) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SQRT;
						sq_req.start = 1'b1;
					end
				end else if (bnd <= d2_q) begin
					state_d = ST_BND;
				end else begin
					state_d = ST_SQRT;
					sq_req.start = 1'b1;
				end
			end
			ST_SQRT: begin
				if (sq_rsp.done) state_d = ST_UPD;
			end
			ST_UPD: state_d = ST_DIVS;
			ST_RD: state_d = sel_ok ? ST_RDW : ST_DONE;
			ST_RDW: state_d = ST_DIVS;
			ST_DIVS: begin
				if (cur_q.count == 32'd0) begin
					state_d = ST_DONE;
				end else begin
					dv_req.start = 1'b1;
					state_d = ST_DIV_RE;
				end
			end
			ST_DIV_RE: begin
				if (dv_rsp.done) begin
					dv_req.start = 1'b1;
					state_d = ST_DIV_IM;
				end
			end
			ST_DIV_IM: begin
				if (dv_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ring_count_q <= 5'd1;
			ring_width_q <= 16'd1;
			out_valid_q  <= 1'b0;
			ring_vld_q   <= '0;
			rd_vld_q     <= 1'b0;
			step_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_RING_COUNT: ring_count_q <= cfg_data[4:0];
					REG_RING_WIDTH: ring_width_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (wr_en) ring_vld_q[k_q] <= 1'b1;
			rd_vld_q <= ring_vld_q[rd_addr];
			if (state_q == ST_SQ) step_q <= step_q + 3'd1;
			else step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_mem[rd_addr];
		if (wr_en) ring_mem[k_q] <= upd;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					u_q   <= u_pos;
					v_q   <= v_pos;
					re_q  <= vis_real;
					im_q  <= vis_imag;
					nz_q  <= vis_noise;
					sel_q <= ring_select;
					n_q   <= n9[CW-1:0];
					r_q   <= RW'(ring_width_q);
					i_q   <= CW'(1);
					k_q   <= '0;
					oor_q <= 1'b0;
				end
			end
			ST_SQ: begin
				case (step_q)
					3'd1: d2_q <= prod_q;
					3'd2: d2_q <= d2_q + prod_q;
					3'd3: p2_q <= prod_q;
					3'd4: p2_q <= p2_q + prod_q;
					default: ;
				endcase
			end
			ST_CMP: begin
				if (i_q == n_q) begin
					if (d2_q > bnd) begin
						oor_q  <= 1'b1;
						ridx_q <= 4'd0;
						cur_q  <= '0;
						mre_q  <= '0;
						mim_q  <= '0;
					end
				end else if (bnd <= d2_q) begin
					k_q <= i_q[AW-1:0];
					i_q <= i_q + CW'(1);
					r_q <= r_q + RW'(ring_width_q);
				end
			end
			ST_UPD: begin
				cur_q  <= upd;
				ridx_q <= k_x[3:0];
			end
			ST_RD: begin
				ridx_q <= sel_q;
				cur_q  <= '0;
				mre_q  <= '0;
				mim_q  <= '0;
			end
			ST_RDW: cur_q <= ent;
			ST_DIVS: begin
				mre_q <= '0;
				mim_q <= '0;
			end
			ST_DIV_RE: begin
				if (dv_rsp.done) mre_q <= mean_clamp(cur_q.real_s[63], quo);
			end
			ST_DIV_IM: begin
				if (dv_rsp.done) mim_q <= mean_clamp(cur_q.imag_s[63], quo);
			end
			default: ;
		endcase
		if (out_load) begin
			ring_index_q <= ridx_q;
			oor_out_q    <= oor_q;
			res_q        <= cur_q;
			rmean_q      <= mre_q;
			imean_q      <= mim_q;
		end
	end

	rbva_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sq_req),
		.radicand (p2_q),
		.rsp      (sq_rsp),
		.root     (mag)
	);

	rbva_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dv_req),
		.dividend (dv_dividend),
		.divisor  (cur_q.count),
		.rsp      (dv_rsp),
		.quotient (quo)
	);

	assign out_valid    = out_valid_q;
	assign ring_index   = ring_index_q;
	assign out_of_range = oor_out_q;
	assign item_count   = res_q.count;
	assign real_sum     = res_q.real_s;
	assign imag_sum     = res_q.imag_s;
	assign power_sum    = res_q.power_s;
	assign noise_sum    = res_q.noise_s;
	assign real_mean    = rmean_q;
	assign imag_mean    = imean_q;

endmodule

FILE: rtl/core/rbva_checker.sv
// Port-level checks for the radial bin visibility accumulator, bound to the top level.
// Depends only on the top level's ports.
module rbva_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         ring_index,
	input logic [0:0]         out_of_range,
	input logic [31:0]        item_count,
	input logic signed [63:0] real_sum,
	input logic signed [63:0] imag_sum,
	input logic [62:0]        power_sum,
	input logic signed [63:0] noise_sum,
	input logic signed [31:0] real_mean,
	input logic signed [31:0] imag_mean
);

	// A dropped item reports ring zero and nothing else.
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range[0] |-> ring_index == 4'd0 && item_count == 32'd0 &&
		real_sum == 64'sd0 && imag_sum == 64'sd0 && power_sum == 63'd0 && noise_sum == 64'sd0)
		else $error("dropped item carries nonzero fields");

	// An empty ring has no means and no accumulated magnitude.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_count == 32'd0 |-> real_mean == 32'sd0 && imag_mean == 32'sd0 &&
		power_sum == 63'd0)
		else $error("empty ring reports nonzero means or power");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(real_sum) && $stable(item_count) &&
		$stable(ring_index))
		else $error("result changed while stalled");

endmodule

bind radial_bin_visibility_accumulator rbva_checker u_rbva_checker (.*);

FILE: dv/radial_bin_visibility_accumulator_tb.sv
// Self-checking testbench for radial_bin_visibility_accumulator: directed and random items
// checked against a ring predictor kept inside the bench, with random idling on both sides.
// Depends on rbva_pkg and the RTL of the block only.
module radial_bin_visibility_accumulator_tb;
	import rbva_pkg::*;

	typedef struct {
		logic [3:0]         ring;
		logic               oor;
		logic [31:0]        cnt;
		logic signed [63:0] re_s;
		logic signed [63:0] im_s;
		logic [62:0]        pw_s;
		logic signed [63:0] nz_s;
		logic signed [31:0] re_m;
		logic signed [31:0] im_m;
	} ring_result_t;

	localparam int RINGS = 16;
	localparam int STALL_LIMIT = 20000;
	localparam logic [62:0] PWR_TOP = {63{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_RING_COUNT;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t op = OP_ADD;
	logic signed [31:0] u_pos = '0, v_pos = '0, vis_real = '0, vis_imag = '0, vis_noise = '0;
	logic [3:0] ring_select = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] ring_index;
	logic [0:0] out_of_range;
	logic [31:0] item_count;
	logic signed [63:0] real_sum, imag_sum, noise_sum;
	logic [62:0] power_sum;
	logic signed [31:0] real_mean, imag_mean;

	// Predictor state.
	logic signed [63:0] re_acc [RINGS];
	logic signed [63:0] im_acc [RINGS];
	logic [62:0]        pw_acc [RINGS];
	logic signed [63:0] nz_acc [RINGS];
	logic [31:0]        cnt_acc [RINGS];
	logic [4:0]         rings_cfg = 5'd1;
	logic [15:0]        width_cfg = 16'd1;

	ring_result_t expected_rings [$];
	int mismatches = 0;
	int n_adds = 0, n_reads = 0, n_drops = 0, n_results = 0;
	int stall_cycles = 0;
	bit calm = 0;
	bit hold_req = 0;
	int hold_cnt = 0;

	radial_bin_visibility_accumulator dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] r, t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
			input logic signed [31:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	// Squared ring bound in Q32.32; all ones when it lies past any reachable distance.
	function automatic logic [63:0] sq_bound(input int unsigned j);
		logic [63:0] r, s;
		r = 64'(j) * 64'(width_cfg);
		s = r * r;
		return (s >= 64'h1_0000_0000) ? '1 : (s << 32);
	endfunction

	function automatic logic [31:0] trunc_mean(input logic signed [63:0] s, input logic [31:0] c);
		logic [63:0] mag, q;
		if (c == 0) return '0;
		mag = s[63] ? (64'd0 - s) : s;
		q = mag / c;
		if (s[63]) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(64'd0 - q);
		end
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	function automatic ring_result_t ring_report(input int k);
		ring_result_t r;
		r.ring = 4'(k);
		r.oor = 1'b0;
		r.cnt = cnt_acc[k];
		r.re_s = re_acc[k];
		r.im_s = im_acc[k];
		r.pw_s = pw_acc[k];
		r.nz_s = nz_acc[k];
		r.re_m = trunc_mean(re_acc[k], cnt_acc[k]);
		r.im_m = trunc_mean(im_acc[k], cnt_acc[k]);
		return r;
	endfunction

	function automatic ring_result_t bin_visibility(input op_t o, input logic signed [31:0] u,
			input logic signed [31:0] v, input logic signed [31:0] re,
			input logic signed [31:0] im, input logic signed [31:0] nz, input logic [3:0] sel);
		ring_result_t r;
		int n, k;
		logic [63:0] au, av, ar, ai, d2, mag;
		if (o == OP_READ) return ring_report(int'(sel));
		n = int'(rings_cfg);
		if (n == 0) n = 1;
		if (n > RINGS) n = RINGS;
		au = u[31] ? 64'(-33'(u)) : 64'(u);
		av = v[31] ? 64'(-33'(v)) : 64'(v);
		d2 = au * au + av * av;
		if (d2 > sq_bound(n)) begin
			r = '{default: '0};
			r.oor = 1'b1;
			return r;
		end
		k = 0;
		for (int i = 1; i < n; i++) if (sq_bound(i) <= d2) k = i;
		ar = re[31] ? 64'(-33'(re)) : 64'(re);
		ai = im[31] ? 64'(-33'(im)) : 64'(im);
		mag = isqrt(ar * ar + ai * ai);
		re_acc[k] = sum_sat(re_acc[k], re);
		im_acc[k] = sum_sat(im_acc[k], im);
		nz_acc[k] = sum_sat(nz_acc[k], nz);
		pw_acc[k] = (64'(pw_acc[k]) > 64'(PWR_TOP) - mag) ? PWR_TOP : pw_acc[k] + mag[62:0];
		if (cnt_acc[k] != '1) cnt_acc[k]++;
		return ring_report(k);
	endfunction

	// Offers one item and returns once it is accepted; valid is left high.
	task automatic send_item(input op_t o, input logic signed [31:0] u,
			input logic signed [31:0] v, input logic signed [31:0] re,
			input logic signed [31:0] im, input logic signed [31:0] nz, input logic [3:0] sel);
		if (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		u_pos <= u;
		v_pos <= v;
		vis_real <= re;
		vis_imag <= im;
		vis_noise <= nz;
		ring_select <= sel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_rings.push_back(bin_visibility(o, u, v, re, im, nz, sel));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_rings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RING_COUNT) rings_cfg = val[4:0];
		else width_cfg = val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] cnt, input logic [15:0] w);
		drain();
		write_reg(REG_RING_COUNT, cnt);
		write_reg(REG_RING_WIDTH, w);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(3))
			0: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// Add aimed at the rings in use, or anywhere in the plane now and then.
	task automatic random_add();
		longint lim, rad;
		logic signed [31:0] u, v;
		int n;
		n = (rings_cfg == 0) ? 1 : (rings_cfg > RINGS ? RINGS : int'(rings_cfg));
		lim = (longint'(n) * width_cfg + width_cfg) * 65536;
		if (lim > 64'sd2147483647) lim = 64'sd2147483647;
		if ($urandom_range(9) == 0) begin
			rad = (longint'($urandom_range(0, n)) * width_cfg) << 16;
			if (rad > lim) rad = lim;
		end else begin
			rad = $urandom_range(0, 32'(lim));
		end
		u = $urandom_range(1) ? -32'(rad) : 32'(rad);
		v = $urandom_range(4) == 0 ? 32'($urandom_range(0, 255)) : 32'd0;
		if ($urandom_range(1)) {u, v} = {v, u};
		if ($urandom_range(6) == 0) begin
			u = $urandom;
			v = $urandom;
		end
		send_item(OP_ADD, u, v, rand_word(), rand_word(), rand_word(), 4'($urandom));
	endtask

	task automatic test_reads_after_reset();
		send_item(OP_READ, '0, '0, '0, '0, '0, 4'd0);
		send_item(OP_READ, '1, '1, '1, '1, '1, 4'd15);
	endtask

	task automatic test_ring_edges();
		configure(4, 3);
		send_item(OP_ADD, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
		send_item(OP_ADD, (3 << 16) - 1, 0, -32'sd5, 32'sd3, -32'sd1, 0);
		send_item(OP_ADD, 3 << 16, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
		send_item(OP_ADD, 0, -(6 << 16), -32'sd7, -32'sd9, 32'sd2, 0);
		// Exactly on the outer bound still belongs to the last ring.
		send_item(OP_ADD, 12 << 16, 0, 32'sd100, -32'sd100, 32'sd1, 0);
		send_item(OP_ADD, 12 << 16, 1, 32'sd1, 32'sd1, 32'sd1, 0);
		send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1, 0);
		send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, 1, 0);
		send_item(OP_ADD, -(9 << 16), -(4 << 16), 32'sh8000_0000, 0, 0, 0);
		for (int i = 0; i < RINGS; i += 3) send_item(OP_READ, 0, 0, 0, 0, 0, 4'(i));
		send_item(OP_READ, 0, 0, 0, 0, 0, 4'd15);
	endtask

	task automatic test_config_extremes();
		// A zero ring count acts as one ring.
		configure(0, 2);
		send_item(OP_ADD, 1 << 16, 1 << 16, 5, 5, 5, 0);
		send_item(OP_ADD, 3 << 16, 0, 5, 5, 5, 0);
		// A count above the store size is clamped.
		configure(31, 65535);
		send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, 0, 0);
		send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 3, 4, 5, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 4'd15);
		// With zero width only the origin is in range.
		configure(16, 0);
		send_item(OP_ADD, 0, 0, 9, 9, 9, 0);
		send_item(OP_ADD, 1, 0, 9, 9, 9, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 4'd15);
	endtask

	task automatic test_random_phases();
		logic [15:0] counts [8] = '{16, 1, 5, 16, 8, 3, 16, 12};
		logic [15:0] widths [8] = '{1, 65535, 7, 4096, 300, 1, 65535, 50};
		for (int p = 0; p < 8; p++) begin
			configure(counts[p], widths[p]);
			calm = (p == 3);
			repeat (150) begin
				if ($urandom_range(4) == 0)
					send_item(OP_READ, rand_word(), rand_word(), rand_word(), rand_word(),
						rand_word(), 4'($urandom));
				else
					random_add();
			end
			calm = 0;
		end
	endtask

	task automatic test_output_stall();
		configure(16, 200);
		drain();
		hold_req = 1;
		repeat (25) random_add();
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt <= 1500;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(99) >= 9;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		ring_result_t e;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_rings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: result with no item outstanding");
			end else begin
				e = expected_rings.pop_front();
				check_field("ring_index", 64'(e.ring), 64'(ring_index));
				check_field("out_of_range", 64'(e.oor), 64'(out_of_range));
				check_field("item_count", 64'(e.cnt), 64'(item_count));
				check_field("real_sum", e.re_s, real_sum);
				check_field("imag_sum", e.im_s, imag_sum);
				check_field("power_sum", 64'(e.pw_s), 64'(power_sum));
				check_field("noise_sum", e.nz_s, noise_sum);
				check_field("real_mean", 64'(e.re_m), 64'(real_mean));
				check_field("imag_mean", 64'(e.im_m), 64'(imag_mean));
				if (e.oor) n_drops++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
			if (in_valid && in_ready) begin
				if (op == OP_READ) n_reads++;
				else n_adds++;
			end
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < RINGS; i++) begin
			re_acc[i] = '0;
			im_acc[i] = '0;
			pw_acc[i] = '0;
			nz_acc[i] = '0;
			cnt_acc[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reads_after_reset();
		test_ring_edges();
		test_config_extremes();
		test_random_phases();
		test_output_stall();
		drain();
		repeat (300) @(posedge clk);
		if (expected_rings.size() != 0) mismatches++;
		$display("Ran %0d adds (%0d dropped as out of range) and %0d reads; %0d results seen.",
			n_adds, n_drops, n_reads, n_results);
		$display("Covered ring bounds, register extremes, random phases and a long output stall.");
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rbva_pkg.sv
rtl/core/rbva_sqrt.sv
rtl/core/rbva_div.sv
rtl/core/radial_bin_visibility_accumulator.sv
rtl/core/rbva_checker.sv
dv/radial_bin_visibility_accumulator_tb.sv
